>>> hdl/segregated_slot_pool_allocator_macros.svh
// assertion macros for the slot pool allocator
`ifndef SEGREGATED_SLOT_POOL_ALLOCATOR_MACROS_SVH
`define SEGREGATED_SLOT_POOL_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define SSPA_ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define SSPA_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

>>> hdl/sspa_pkg.sv
// shared constants for the slot pool allocator
`default_nettype none
package sspa_pkg;

   // field widths of the item ports
   localparam int MODE_W  = 1;
   localparam int CLASS_W = 3;
   localparam int SLOT_W  = 7;
   localparam int CAP_W   = 8;

   // capacity limit after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 8'd100;

   // request modes
   localparam logic [MODE_W-1:0] MODE_ALLOC   = 1'b0;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 1'b1;

   // response status codes
   localparam logic STATUS_DONE      = 1'b0;
   localparam logic STATUS_EXHAUSTED = 1'b1;

endpackage
`default_nettype wire

>>> hdl/sspa_ram.sv
// single-port-write, single-port-read synchronous ram with registered read data
`default_nettype none
module sspa_ram
   import sspa_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hdl/segregated_slot_pool_allocator.sv
// slot pool allocator with one lifo free list per object class
//
//   port group  | dir | handshake         | content
//   req_*       | in  | valid / ready     | mode, object class, release slot
//   rsp_*       | out | valid / ready     | granted slot, status
//   csr_*       | in  | write enable only | capacity limit
//
// a release or a fresh/exhausted allocate ends after the head memory read; a
// pop reads the head memory, then the link memory at that head
// one item is in flight at a time; the next is taken once the last is done
// a waiting result sits in the output register while the next item is taken;
// that item holds after its head read until the waiting result is taken
// reset is synchronous; head entries read as empty until first written
`default_nettype none
module segregated_slot_pool_allocator
   import sspa_pkg::*;
#(
   parameter int SLOTS   = 128,
   parameter int CLASSES = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [MODE_W-1:0]  req_mode,
   input  wire logic [CLASS_W-1:0] req_object_class,
   input  wire logic [SLOT_W-1:0]  req_release_slot,
   // response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [SLOT_W-1:0]       rsp_granted_slot,
   output logic                    rsp_status,
   // configuration
   input  wire logic               csr_we,
   input  wire logic [CAP_W-1:0]   csr_wdata
);

   localparam int IDX_W   = $clog2(SLOTS);
   localparam int LINK_W  = $clog2(SLOTS + 1);
   localparam int CIDX_W  = (CLASSES > 1) ? $clog2(CLASSES) : 1;
   localparam int FRESH_W = $clog2(SLOTS + 1);
   localparam logic [LINK_W-1:0] EMPTY = LINK_W'(SLOTS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HEAD,
      ST_LINK
   } state_type;

   state_type           state_ff;
   logic [CAP_W-1:0]    cap_ff;
   logic [FRESH_W-1:0]  fresh_ff;
   logic [CLASSES-1:0]  head_valid_ff;
   logic                head_hit_ff;
   logic [MODE_W-1:0]   mode_ff;
   logic                cls_ok_ff;
   logic                slot_ok_ff;
   logic [CIDX_W-1:0]   cidx_ff;
   logic [IDX_W-1:0]    sidx_ff;
   logic                rsp_valid_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic                rsp_status_ff;

   logic                accept;
   logic                out_free;
   logic                rsp_load;
   logic                req_cls_ok;
   logic [CIDX_W-1:0]   req_cidx;
   logic [LINK_W-1:0]   head_rd;
   logic [LINK_W-1:0]   link_rd;
   logic [LINK_W-1:0]   head_val;
   logic                pop;
   logic                release_ok;
   logic                fresh_ok;
   logic                head_we;
   logic [LINK_W-1:0]   head_wdata;
   logic                link_we;
   logic                link_re;

   // request decode
   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_cls_ok = (32'(req_object_class) < 32'(CLASSES));
   assign req_cidx   = req_cls_ok ? CIDX_W'(req_object_class) : '0;

   // current head of the selected class, empty until first written
   assign head_val   = head_hit_ff ? head_rd : EMPTY;
   assign pop        = (mode_ff == MODE_ALLOC) && cls_ok_ff && (head_val != EMPTY);
   assign release_ok = (mode_ff == MODE_RELEASE) && cls_ok_ff && slot_ok_ff;
   assign fresh_ok   = (32'(fresh_ff) < 32'(cap_ff)) && (32'(fresh_ff) < 32'(SLOTS));

   // result register load
   assign rsp_load   = out_free && (((state_ff == ST_HEAD) && !pop) || (state_ff == ST_LINK));

   // memory control
   assign link_we    = (state_ff == ST_HEAD) && out_free && release_ok;
   assign link_re    = (state_ff == ST_HEAD) && pop;
   assign head_we    = link_we || ((state_ff == ST_LINK) && out_free);
   assign head_wdata = (state_ff == ST_HEAD) ? LINK_W'(sidx_ff) : link_rd;

   sspa_ram #(
      .WIDTH (LINK_W),
      .DEPTH (CLASSES),
      .AW    (CIDX_W)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (cidx_ff),
      .wr_data (head_wdata),
      .rd_en   (accept),
      .rd_addr (req_cidx),
      .rd_data (head_rd)
   );

   sspa_ram #(
      .WIDTH (LINK_W),
      .DEPTH (SLOTS),
      .AW    (IDX_W)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (sidx_ff),
      .wr_data (head_val),
      .rd_en   (link_re),
      .rd_addr (head_val[IDX_W-1:0]),
      .rd_data (link_rd)
   );

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_we) begin
         cap_ff <= csr_wdata;
      end
   end

   // head valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= '0;
      end else if (head_we) begin
         head_valid_ff[cidx_ff] <= 1'b1;
      end
   end

   // captured request fields
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff     <= req_mode;
         cls_ok_ff   <= req_cls_ok;
         slot_ok_ff  <= (32'(req_release_slot) < 32'(SLOTS));
         cidx_ff     <= req_cidx;
         sidx_ff     <= IDX_W'(req_release_slot);
         head_hit_ff <= head_valid_ff[req_cidx];
      end
   end

   // sequencer, fresh counter and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fresh_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_slot_ff   <= '0;
         rsp_status_ff <= STATUS_DONE;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_HEAD;
               end
            end
            ST_HEAD: begin
               if (out_free) begin
                  if (pop) begin
                     rsp_slot_ff <= SLOT_W'(head_val);
                     state_ff    <= ST_LINK;
                  end else begin
                     state_ff <= ST_IDLE;
                     if (mode_ff == MODE_RELEASE) begin
                        rsp_slot_ff   <= '0;
                        rsp_status_ff <= STATUS_DONE;
                     end else if (fresh_ok) begin
                        rsp_slot_ff   <= SLOT_W'(fresh_ff);
                        rsp_status_ff <= STATUS_DONE;
                        fresh_ff      <= fresh_ff + FRESH_W'(1);
                     end else begin
                        rsp_slot_ff   <= '0;
                        rsp_status_ff <= STATUS_EXHAUSTED;
                     end
                  end
               end
            end
            ST_LINK: begin
               if (out_free) begin
                  rsp_status_ff <= STATUS_DONE;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_slot = rsp_slot_ff;
   assign rsp_status       = rsp_status_ff;

   // checks
   `include "segregated_slot_pool_allocator_macros.svh"

   `SSPA_ASSERT_NEXT(a_accept_to_head, clock, reset, accept, state_ff == ST_HEAD, "item not started")
   `SSPA_ASSERT_IMPLY(a_link_with_head, clock, reset, link_we, head_we, "link write without head write")
   `SSPA_ASSERT_IMPLY(a_fresh_bound, clock, reset, 1'b1, 32'(fresh_ff) <= 32'(SLOTS), "fresh count over pool")
   `SSPA_ASSERT_IMPLY(a_exhausted_zero, clock, reset, rsp_valid_ff && (rsp_status_ff == STATUS_EXHAUSTED), rsp_slot_ff == '0, "exhausted with slot")

endmodule
`default_nettype wire
